FILE: src/ihcc_pkg.sv
package ihcc_pkg;

    localparam int unsigned HDR_LEN      = 20;
    localparam logic [7:0]  VERLEN_OK    = 8'h45;

    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;

    localparam logic [2:0]  VERDICT_ACCEPT    = 3'd0;
    localparam logic [2:0]  VERDICT_BAD_VER   = 3'd1;
    localparam logic [2:0]  VERDICT_WRONG_DST = 3'd2;
    localparam logic [2:0]  VERDICT_BAD_CSUM  = 3'd3;
    localparam logic [2:0]  VERDICT_SHORT     = 3'd4;

    localparam logic [1:0]  CLASS_ICMP  = 2'd0;
    localparam logic [1:0]  CLASS_TCP   = 2'd1;
    localparam logic [1:0]  CLASS_UDP   = 2'd2;
    localparam logic [1:0]  CLASS_OTHER = 2'd3;

    // header byte positions
    localparam logic [4:0]  POS_VERLEN   = 5'd0;
    localparam logic [4:0]  POS_TLEN_HI  = 5'd2;
    localparam logic [4:0]  POS_TLEN_LO  = 5'd3;
    localparam logic [4:0]  POS_PROTO    = 5'd9;
    localparam logic [4:0]  POS_CSUM_HI  = 5'd10;
    localparam logic [4:0]  POS_CSUM_LO  = 5'd11;
    localparam logic [4:0]  POS_DST0     = 5'd16;
    localparam logic [4:0]  POS_LAST_HDR = 5'd19;
    localparam logic [4:0]  POS_DONE     = 5'd20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  protocol_class;
        logic [15:0] payload_length;
    } out_item_t;

    function automatic logic [1:0] class_of(input logic [7:0] proto);
        logic [1:0] c;
        case (proto)
            PROTO_ICMP: c = CLASS_ICMP;
            PROTO_TCP:  c = CLASS_TCP;
            PROTO_UDP:  c = CLASS_UDP;
            default:    c = CLASS_OTHER;
        endcase
        return c;
    endfunction

endpackage

FILE: src/ihcc_in_stage.sv
module ihcc_in_stage
    import ihcc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    output logic     q_valid,
    input  logic     q_take,
    output in_item_t q_item
);

    logic     valid_reg;
    in_item_t item_reg;

    // refill in the same cycle the held byte is consumed
    assign s_ready = !valid_reg || q_take;
    assign q_valid = valid_reg;
    assign q_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: src/ihcc_parser.sv
module ihcc_parser
    import ihcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic      step,
    input  in_item_t  item,
    output logic      res_valid,
    output out_item_t res_item
);

    logic [31:0] own_ip_reg;
    logic [4:0]  pos_reg,   pos_next;
    logic [19:0] sum_reg,   sum_next;
    logic [15:0] csum_reg,  csum_next;
    logic        ver_ok_reg, ver_ok_next;
    logic        addr_ok_reg, addr_ok_next;
    logic [7:0]  proto_reg, proto_next;
    logic [15:0] tlen_reg,  tlen_next;

    logic [7:0]  b;
    logic [7:0]  own_byte;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] calc;
    logic [2:0]  verdict;
    logic [19:0] addend;

    assign b = item.data_byte;

    always_comb begin
        case (pos_reg[1:0])
            2'd0:    own_byte = own_ip_reg[31:24];
            2'd1:    own_byte = own_ip_reg[23:16];
            2'd2:    own_byte = own_ip_reg[15:8];
            default: own_byte = own_ip_reg[7:0];
        endcase
    end

    assign addend = pos_reg[0] ? {12'd0, b} : {4'd0, b, 8'd0};

    always_comb begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        csum_next    = csum_reg;
        ver_ok_next  = ver_ok_reg;
        addr_ok_next = addr_ok_reg;
        proto_next   = proto_reg;
        tlen_next    = tlen_reg;
        res_valid    = 1'b0;
        res_item     = '0;

        if (pos_reg < POS_DONE) begin
            if (pos_reg == POS_VERLEN)  ver_ok_next = (b == VERLEN_OK);
            if (pos_reg == POS_TLEN_HI) tlen_next[15:8] = b;
            if (pos_reg == POS_TLEN_LO) tlen_next[7:0] = b;
            if (pos_reg == POS_PROTO)   proto_next = b;
            if (pos_reg == POS_CSUM_HI) begin
                csum_next[15:8] = b;
            end else if (pos_reg == POS_CSUM_LO) begin
                csum_next[7:0] = b;
            end else begin
                sum_next = sum_reg + addend;
            end
            if (pos_reg >= POS_DST0 && own_byte != b) addr_ok_next = 1'b0;
        end

        // end-around carry fold of the final sum
        fold1 = {1'b0, sum_next[15:0]} + {13'd0, sum_next[19:16]};
        fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        calc  = ~fold2[15:0];

        if (!ver_ok_reg)           verdict = VERDICT_BAD_VER;
        else if (!addr_ok_next)    verdict = VERDICT_WRONG_DST;
        else if (calc != csum_reg) verdict = VERDICT_BAD_CSUM;
        else                       verdict = VERDICT_ACCEPT;

        if (pos_reg < POS_DONE) begin
            if (pos_reg == POS_LAST_HDR) begin
                res_valid        = 1'b1;
                res_item.verdict = verdict;
                if (verdict == VERDICT_ACCEPT) begin
                    res_item.protocol_class = class_of(proto_reg);
                    res_item.payload_length = (tlen_reg > 16'(HDR_LEN)) ?
                                              tlen_reg - 16'(HDR_LEN) : 16'd0;
                end
                pos_next = POS_DONE;
            end else if (item.last_byte) begin
                res_valid        = 1'b1;
                res_item.verdict = VERDICT_SHORT;
            end else begin
                pos_next = pos_reg + 5'd1;
            end
        end

        if (item.last_byte) begin
            pos_next     = '0;
            sum_next     = '0;
            csum_next    = '0;
            ver_ok_next  = 1'b0;
            addr_ok_next = 1'b1;
            proto_next   = '0;
            tlen_next    = '0;
        end

        if (!step) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_ip_reg  <= '0;
            pos_reg     <= '0;
            sum_reg     <= '0;
            csum_reg    <= '0;
            ver_ok_reg  <= 1'b0;
            addr_ok_reg <= 1'b1;
            proto_reg   <= '0;
            tlen_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                own_ip_reg <= cfg_data;
            end
            if (step) begin
                pos_reg     <= pos_next;
                sum_reg     <= sum_next;
                csum_reg    <= csum_next;
                ver_ok_reg  <= ver_ok_next;
                addr_ok_reg <= addr_ok_next;
                proto_reg   <= proto_next;
                tlen_reg    <= tlen_next;
            end
        end
    end

endmodule

FILE: src/ihcc_out_stage.sv
module ihcc_out_stage
    import ihcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  logic      d_valid,
    input  out_item_t d_item,
    output logic      free,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    out_item_t item_reg;

    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= d_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
        if (load && d_valid) begin
            item_reg <= d_item;
        end
    end

endmodule

FILE: src/ipv4_header_check_classify_core.sv
// Channel   Direction  Handshake                 Payload
// s_        in         s_valid / s_ready         s_item    (data_byte, last_byte)
// m_        out        m_valid / m_ready         m_item    (verdict, class, length)
// cfg_      in         cfg_valid / cfg_ready     cfg_data  (own IPv4 address)
//
// One byte per cycle unless a held result stalls; the byte sits in the input
// register after its transfer and the result register loads on the parse step,
// so a verdict for header byte 19 (or the short byte) follows on m_valid.
// Reset is synchronous on aresetn low: own address 0, parser at header byte 0.
// A held result stalls the parse stage; s_ready then drops once the input
// register is full. cfg_ready is always high.
module ipv4_header_check_classify_core
    import ihcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic      q_valid;
    in_item_t  q_item;
    logic      step;
    logic      out_free;
    logic      res_valid;
    out_item_t res_item;

    assign cfg_ready = 1'b1;
    assign step      = q_valid && out_free;

    ihcc_in_stage u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_valid (q_valid),
        .q_take  (step),
        .q_item  (q_item)
    );

    ihcc_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (q_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    ihcc_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (step),
        .d_valid (res_valid),
        .d_item  (res_item),
        .free    (out_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule
